### design/sme_pkg.sv
// sme_pkg: shared types and constants for the stable matching engine
// used by sme_pref_store and stable_matching_engine
`default_nettype none

package sme_pkg;

    localparam logic OP_PROPOSER = 1'b0;
    localparam logic OP_RECEIVER = 1'b1;

    // control for the preference store
    typedef struct packed {
        logic wr_en;
        logic wr_rank;
        logic prop_rd;
        logic rank_rd;
    } t_pref_ctl;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_INIT     = 11'b00000000010,
        S_POP      = 11'b00000000100,
        S_GETP     = 11'b00000001000,
        S_GETPTR   = 11'b00000010000,
        S_GETR     = 11'b00000100000,
        S_GETOLD   = 11'b00001000000,
        S_CMP      = 11'b00010000000,
        S_OUT_RD   = 11'b00100000000,
        S_OUT_LD   = 11'b01000000000,
        S_OUT_WAIT = 11'b10000000000
    } t_state;

endpackage

`default_nettype wire

### design/sme_pref_store.sv
// sme_pref_store: proposer choice memory and inverted receiver rank memory
// one write port shared by both, one registered read port each; uses sme_pkg
`default_nettype none

module sme_pref_store
    import sme_pkg::*;
#(
    parameter int MAX_PAIRS = 16
) (
    input  wire                           i_clk,
    input  wire t_pref_ctl                i_ctl,
    input  wire [$clog2(MAX_PAIRS)-1:0]   i_wr_hi,
    input  wire [$clog2(MAX_PAIRS)-1:0]   i_wr_lo,
    input  wire [$clog2(MAX_PAIRS)-1:0]   i_wr_val,
    input  wire [$clog2(MAX_PAIRS)-1:0]   i_prop_hi,
    input  wire [$clog2(MAX_PAIRS)-1:0]   i_prop_lo,
    input  wire [$clog2(MAX_PAIRS)-1:0]   i_rank_hi,
    input  wire [$clog2(MAX_PAIRS)-1:0]   i_rank_lo,
    output logic [$clog2(MAX_PAIRS)-1:0]  o_prop_q,
    output logic [$clog2(MAX_PAIRS)-1:0]  o_rank_q
);

    localparam int PW    = $clog2(MAX_PAIRS);
    localparam int DEPTH = MAX_PAIRS * MAX_PAIRS;
    localparam int AW    = $clog2(DEPTH);

    logic [PW-1:0] r_prop_mem [DEPTH];
    logic [PW-1:0] r_rank_mem [DEPTH];

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] prop_addr;
    logic [AW-1:0] rank_addr;

    assign wr_addr   = AW'(32'(i_wr_hi) * MAX_PAIRS + 32'(i_wr_lo));
    assign prop_addr = AW'(32'(i_prop_hi) * MAX_PAIRS + 32'(i_prop_lo));
    assign rank_addr = AW'(32'(i_rank_hi) * MAX_PAIRS + 32'(i_rank_lo));

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !i_ctl.wr_rank) begin
            r_prop_mem[wr_addr] <= i_wr_val;
        end
        if (i_ctl.prop_rd) begin
            o_prop_q <= r_prop_mem[prop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_rank) begin
            r_rank_mem[wr_addr] <= i_wr_val;
        end
        if (i_ctl.rank_rd) begin
            o_rank_q <= r_rank_mem[rank_addr];
        end
    end

endmodule

`default_nettype wire

### design/stable_matching_engine.sv
// stable_matching_engine: top level, load path, proposal sequencer, result beats
// uses sme_pkg and sme_pref_store
`default_nettype none

// Preference entries load one per cycle while idle: a proposer entry stores the
// receiver at a list position, a receiver entry stores the rank she gives a
// proposer. An entry with person or choice outside 1..MAX_PAIRS, or position at
// or above MAX_PAIRS, is dropped. An entry with last_entry set starts a
// proposer-optimal matching run over n = pair_count pairs (saturated into
// 1..MAX_PAIRS); input stays stalled until all n result beats, one per receiver
// in order, are taken. A run seeds the free stack with all n proposers, then
// handles up to n*n proposals, the steps of one sequencer sharing one comparator
// and memories with one read port each, then reads, loads and shows each result
// beat, held through any output stall. An unmatched receiver reports partner 0.

module stable_matching_engine
    import sme_pkg::*;
#(
    parameter int MAX_PAIRS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [4:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_opcode,
    input  wire  [4:0] i_person,
    input  wire  [3:0] i_position,
    input  wire  [4:0] i_choice,
    input  wire        i_last_entry,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [4:0] o_receiver,
    output logic [4:0] o_partner,
    output logic       o_last_result
);

    localparam int PW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);

    t_state        r_state, n_state;
    logic [4:0]    r_pair_count;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_depth, n_depth;
    logic [PW-1:0] r_p, n_p;
    logic [PW-1:0] r_r, n_r;
    logic [PW-1:0] r_rank_new, n_rank_new;
    logic [PW-1:0] r_old, n_old;

    logic [PW-1:0] r_stk_mem [MAX_PAIRS];
    logic [CW-1:0] r_ptr_mem [MAX_PAIRS];
    logic [PW-1:0] r_cp_mem  [MAX_PAIRS];
    logic [PW-1:0] r_stk_q;
    logic [CW-1:0] r_ptr_q;
    logic [PW-1:0] r_cp_q;
    logic [MAX_PAIRS-1:0] r_ptr_vld;
    logic [MAX_PAIRS-1:0] r_cp_vld;

    logic          r_out_valid;
    logic [4:0]    r_receiver, n_receiver;
    logic [4:0]    r_partner, n_partner;
    logic          r_last_result, n_last_result;
    logic          n_out_valid;

    logic          in_acc;
    logic          ent_ok;
    logic [CW-1:0] n_sat;
    logic          clr_vld;

    logic          stk_we;
    logic [PW-1:0] stk_wa, stk_wd, stk_ra;
    logic          ptr_we;
    logic [CW-1:0] ptr_wd;
    logic [PW-1:0] ptr_ra;
    logic          cp_we;
    logic [PW-1:0] cp_wa, cp_wd, cp_ra;

    t_pref_ctl     pref_ctl;
    logic [PW-1:0] wr_hi, wr_lo, wr_val;
    logic [PW-1:0] prop_hi, prop_lo, rank_hi, rank_lo;
    logic [PW-1:0] prop_q, rank_q;

    logic [CW-1:0] cmp_a, cmp_b;
    logic          cmp_lt;
    logic [CW-1:0] ptr_cur;
    logic [CW-1:0] depth_m1;
    logic [CW-1:0] cnt_p1;

    logic          push_en;
    logic [PW-1:0] push_val;

    assign o_in_stall    = (r_state != S_IDLE);
    assign in_acc        = i_in_valid && !o_in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_receiver    = r_receiver;
    assign o_partner     = r_partner;
    assign o_last_result = r_last_result;

    assign ent_ok = (i_person != 5'd0) && (32'(i_person) <= MAX_PAIRS)
                 && (i_choice != 5'd0) && (32'(i_choice) <= MAX_PAIRS)
                 && (32'(i_position) < MAX_PAIRS);

    always_comb begin
        if (r_pair_count == 5'd0) begin
            n_sat = CW'(1);
        end else if (32'(r_pair_count) > MAX_PAIRS) begin
            n_sat = CW'(MAX_PAIRS);
        end else begin
            n_sat = CW'(r_pair_count);
        end
    end

    // load path
    always_comb begin
        wr_hi = PW'(32'(i_person) - 32'd1);
        if (i_opcode == OP_RECEIVER) begin
            wr_lo  = PW'(32'(i_choice) - 32'd1);
            wr_val = PW'(32'(i_position));
        end else begin
            wr_lo  = PW'(32'(i_position));
            wr_val = PW'(32'(i_choice) - 32'd1);
        end
    end

    assign ptr_cur  = r_ptr_vld[r_p] ? r_ptr_q : '0;
    assign depth_m1 = r_depth - CW'(1);
    assign cnt_p1   = r_cnt + CW'(1);

    // shared comparator
    always_comb begin
        unique case (r_state)
            S_GETPTR: begin
                cmp_a = ptr_cur;
                cmp_b = r_n;
            end
            S_GETR: begin
                cmp_a = CW'(prop_q);
                cmp_b = r_n;
            end
            default: begin
                cmp_a = CW'(r_rank_new);
                cmp_b = CW'(rank_q);
            end
        endcase
    end
    assign cmp_lt = (cmp_a < cmp_b);

    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_cnt         = r_cnt;
        n_depth       = r_depth;
        n_p           = r_p;
        n_r           = r_r;
        n_rank_new    = r_rank_new;
        n_old         = r_old;
        n_out_valid   = r_out_valid;
        n_receiver    = r_receiver;
        n_partner     = r_partner;
        n_last_result = r_last_result;
        clr_vld       = 1'b0;
        stk_we        = 1'b0;
        stk_wa        = '0;
        stk_wd        = '0;
        stk_ra        = depth_m1[PW-1:0];
        ptr_we        = 1'b0;
        ptr_wd        = ptr_cur + CW'(1);
        ptr_ra        = r_stk_q;
        cp_we         = 1'b0;
        cp_wa         = r_r;
        cp_wd         = r_p;
        cp_ra         = prop_q;
        push_en       = 1'b0;
        push_val      = r_p;
        pref_ctl      = '{wr_en: in_acc && ent_ok, wr_rank: (i_opcode == OP_RECEIVER),
                          prop_rd: 1'b0, rank_rd: 1'b0};
        prop_hi       = r_p;
        prop_lo       = ptr_cur[PW-1:0];
        rank_hi       = prop_q;
        rank_lo       = r_p;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_last_entry) begin
                    n_n     = n_sat;
                    n_cnt   = '0;
                    clr_vld = 1'b1;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                stk_we = 1'b1;
                stk_wa = r_cnt[PW-1:0];
                stk_wd = PW'(r_n - cnt_p1);
                n_cnt  = cnt_p1;
                if (cnt_p1 == r_n) begin
                    n_depth = r_n;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_depth == '0) begin
                    n_cnt   = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_depth = depth_m1;
                    n_state = S_GETP;
                end
            end
            S_GETP: begin
                n_p     = r_stk_q;
                n_state = S_GETPTR;
            end
            S_GETPTR: begin
                if (cmp_lt) begin
                    ptr_we           = 1'b1;
                    pref_ctl.prop_rd = 1'b1;
                    n_state          = S_GETR;
                end else begin
                    n_state = S_POP;
                end
            end
            S_GETR: begin
                if (cmp_lt) begin
                    n_r              = prop_q;
                    pref_ctl.rank_rd = 1'b1;
                    n_state          = S_GETOLD;
                end else begin
                    push_en = 1'b1;
                    n_state = S_POP;
                end
            end
            S_GETOLD: begin
                if (!r_cp_vld[r_r]) begin
                    cp_we   = 1'b1;
                    n_state = S_POP;
                end else begin
                    n_rank_new       = rank_q;
                    n_old            = r_cp_q;
                    pref_ctl.rank_rd = 1'b1;
                    rank_hi          = r_r;
                    rank_lo          = r_cp_q;
                    n_state          = S_CMP;
                end
            end
            S_CMP: begin
                push_en = 1'b1;
                if (cmp_lt) begin
                    cp_we    = 1'b1;
                    push_val = r_old;
                end
                n_state = S_POP;
            end
            S_OUT_RD: begin
                cp_ra   = r_cnt[PW-1:0];
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_out_valid   = 1'b1;
                n_receiver    = 5'(32'(r_cnt) + 32'd1);
                n_partner     = r_cp_vld[r_cnt[PW-1:0]] ? 5'(32'(r_cp_q) + 32'd1) : 5'd0;
                n_last_result = (cnt_p1 == r_n);
                n_state       = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_last_result) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = cnt_p1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_en && (32'(r_depth) < MAX_PAIRS)) begin
            stk_we  = 1'b1;
            stk_wa  = r_depth[PW-1:0];
            stk_wd  = push_val;
            n_depth = r_depth + CW'(1);
        end
    end

    sme_pref_store #(
        .MAX_PAIRS(MAX_PAIRS)
    ) u_pref (
        .i_clk     (i_clk),
        .i_ctl     (pref_ctl),
        .i_wr_hi   (wr_hi),
        .i_wr_lo   (wr_lo),
        .i_wr_val  (wr_val),
        .i_prop_hi (prop_hi),
        .i_prop_lo (prop_lo),
        .i_rank_hi (rank_hi),
        .i_rank_lo (rank_lo),
        .o_prop_q  (prop_q),
        .o_rank_q  (rank_q)
    );

    // free stack, choice pointers, current partners
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_q <= r_stk_mem[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ptr_we) begin
            r_ptr_mem[r_p] <= ptr_wd;
        end
        r_ptr_q <= r_ptr_mem[ptr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cp_we) begin
            r_cp_mem[cp_wa] <= cp_wd;
        end
        r_cp_q <= r_cp_mem[cp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_vld <= '0;
            r_cp_vld  <= '0;
        end else if (clr_vld) begin
            r_ptr_vld <= '0;
            r_cp_vld  <= '0;
        end else begin
            if (ptr_we) begin
                r_ptr_vld[r_p] <= 1'b1;
            end
            if (cp_we) begin
                r_cp_vld[cp_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pair_count <= 5'd16;
            r_n          <= CW'(MAX_PAIRS);
            r_cnt        <= '0;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_cnt       <= n_cnt;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pair_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p           <= n_p;
        r_r           <= n_r;
        r_rank_new    <= n_rank_new;
        r_old         <= n_old;
        r_receiver    <= n_receiver;
        r_partner     <= n_partner;
        r_last_result <= n_last_result;
    end

    // checks
    a_out_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid == (r_state == S_OUT_WAIT))
        else $error("result beat outside the output wait state");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_n)
        else $error("free stack deeper than the pair count");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && r_last_result) |=> (r_state == S_IDLE))
        else $error("final result beat did not return to idle");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_entry) |=> (r_state == S_INIT && r_ptr_vld == '0
                                      && r_cp_vld == '0))
        else $error("run start did not clear matching state");

endmodule

`default_nettype wire
